### src/english_number_words_parser_macros.svh
// assertion macros for the checker
// each macro expands to one labeled concurrent assertion on i_clk,
// disabled while i_rst_n is low
`ifndef ENGLISH_NUMBER_WORDS_PARSER_MACROS_SVH
`define ENGLISH_NUMBER_WORDS_PARSER_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define ENWP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("enwp check failed");

// condition in this cycle implies consequence in the next cycle
`define ENWP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("enwp check failed");

`endif

### src/enwp_pkg.sv
// ----------------------------------------------------------------------------
// enwp_pkg
// types, vocabulary and constants of the number word parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package enwp_pkg;

    // default longest word kept in the word buffer
    localparam int MAX_WORD_LEN_DEF = 9;

    // value range of the result
    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    // character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // scale factors
    localparam int FACTOR_W = 20;
    localparam logic [FACTOR_W-1:0] FACTOR_HUNDRED  = 20'd100;
    localparam logic [FACTOR_W-1:0] FACTOR_THOUSAND = 20'd1000;
    localparam logic [FACTOR_W-1:0] FACTOR_MILLION  = 20'd1000000;

    // token queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // kind of a closed word
    typedef enum logic [2:0] {
        WK_NONE,
        WK_PLUS,
        WK_HUNDRED,
        WK_THOUSAND,
        WK_MILLION,
        WK_ZERO
    } t_word_kind;

    typedef struct packed {
        t_word_kind  kind;
        logic [6:0]  value;
    } t_word_class;

    // one closed word handed from front to back
    typedef struct packed {
        t_word_kind  kind;
        logic [6:0]  value;
        logic        last;
    } t_token;

    // queue status seen by front and back
    typedef struct packed {
        logic can_push;
        logic head_valid;
    } t_q_status;

    // vocabulary, text right-justified with the first letter highest
    localparam int VOC_CHARS = 9;
    localparam int VOC_LEN_W = 4;
    localparam int VOC_COUNT = 31;

    localparam logic [8*VOC_CHARS-1:0] VOC_TEXT [VOC_COUNT] = '{
        "zero", "one", "two", "three", "four", "five", "six", "seven",
        "eight", "nine", "ten", "eleven", "twelve", "thirteen", "fourteen",
        "fifteen", "sixteen", "seventeen", "eighteen", "nineteen", "twenty",
        "thirty", "forty", "fifty", "sixty", "seventy", "eighty", "ninety",
        "hundred", "thousand", "million"
    };

    localparam logic [VOC_LEN_W-1:0] VOC_LEN [VOC_COUNT] = '{
        4'd4, 4'd3, 4'd3, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5,
        4'd5, 4'd4, 4'd3, 4'd6, 4'd6, 4'd8, 4'd8,
        4'd7, 4'd7, 4'd9, 4'd8, 4'd8, 4'd6,
        4'd6, 4'd5, 4'd5, 4'd5, 4'd7, 4'd6, 4'd6,
        4'd7, 4'd8, 4'd7
    };

    localparam t_word_class VOC_CLASS [VOC_COUNT] = '{
        '{WK_ZERO, 7'd0},   '{WK_PLUS, 7'd1},   '{WK_PLUS, 7'd2},
        '{WK_PLUS, 7'd3},   '{WK_PLUS, 7'd4},   '{WK_PLUS, 7'd5},
        '{WK_PLUS, 7'd6},   '{WK_PLUS, 7'd7},   '{WK_PLUS, 7'd8},
        '{WK_PLUS, 7'd9},   '{WK_PLUS, 7'd10},  '{WK_PLUS, 7'd11},
        '{WK_PLUS, 7'd12},  '{WK_PLUS, 7'd13},  '{WK_PLUS, 7'd14},
        '{WK_PLUS, 7'd15},  '{WK_PLUS, 7'd16},  '{WK_PLUS, 7'd17},
        '{WK_PLUS, 7'd18},  '{WK_PLUS, 7'd19},  '{WK_PLUS, 7'd20},
        '{WK_PLUS, 7'd30},  '{WK_PLUS, 7'd40},  '{WK_PLUS, 7'd50},
        '{WK_PLUS, 7'd60},  '{WK_PLUS, 7'd70},  '{WK_PLUS, 7'd80},
        '{WK_PLUS, 7'd90},  '{WK_HUNDRED, 7'd0}, '{WK_THOUSAND, 7'd0},
        '{WK_MILLION, 7'd0}
    };

    // match a word of len characters, chars[7:0] is the first one
    function automatic t_word_class classify_word(
        input logic [8*VOC_CHARS-1:0] chars,
        input logic [VOC_LEN_W-1:0]   len
    );
        logic [8*VOC_CHARS-1:0] key;
        t_word_class            res;
        key = '0;
        res = '{WK_NONE, 7'd0};
        for (int p = 0; p < VOC_CHARS; p++) begin
            if (VOC_LEN_W'(p) < len) begin
                key = {key[8*VOC_CHARS-9:0], chars[p*8 +: 8]};
            end
        end
        for (int e = 0; e < VOC_COUNT; e++) begin
            if (len == VOC_LEN[e] && key == VOC_TEXT[e]) begin
                res = VOC_CLASS[e];
            end
        end
        return res;
    endfunction

endpackage

### src/english_number_words_parser.sv
// result: the item that ends the string closes a token that is registered in the token
//   queue, then popped into the result register behind o_m_axis_tvalid after any tokens ahead
// throughput: the front takes one character per cycle while the 4-entry token queue has room;
//   the back applies one token per cycle but holds a closing token while the result register waits
// reset: synchronous active low; clears sums, flags, word length and queue pointers,
//   the letter buffer is not cleared and is only read below the word length
// ----------------------------------------------------------------------------
// english_number_words_parser
// converts a stream of english number words into a saturated integer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module english_number_words_parser #(
    parameter int MAX_WORD_LEN = enwp_pkg::MAX_WORD_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] char_code
    input  logic [7:0]  i_s_axis_tdata,
    // [0] char_present
    input  logic        i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [30:0] number_value, [31] padding, held clear
    output logic [31:0] o_m_axis_tdata,
    // [0] overflowed
    output logic        o_m_axis_tuser
);
    import enwp_pkg::*;

    logic        push;
    logic        pop;
    t_token      push_token;
    t_token      head_token;
    t_q_status   q_status;
    logic [30:0] number_value;

    // character side
    enwp_front #(
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_char     (i_s_axis_tdata),
        .i_present  (i_s_axis_tuser),
        .i_last     (i_s_axis_tlast),
        .i_q_status (q_status),
        .o_push     (push),
        .o_token    (push_token)
    );

    // token queue
    enwp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_token  (push_token),
        .i_pop    (pop),
        .o_head   (head_token),
        .o_status (q_status)
    );

    // accumulator and result side
    enwp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_token),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_value      (number_value),
        .o_overflowed (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {1'b0, number_value};

endmodule

### src/enwp_front.sv
// ----------------------------------------------------------------------------
// enwp_front
// takes characters, gathers words and turns each closed word into a token
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module enwp_front #(
    parameter int MAX_WORD_LEN = enwp_pkg::MAX_WORD_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char,
    input  logic               i_present,
    input  logic               i_last,
    input  enwp_pkg::t_q_status i_q_status,
    output logic               o_push,
    output enwp_pkg::t_token   o_token
);
    import enwp_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W = $clog2(MAX_WORD_LEN);

    logic [7:0]       r_word_chars [MAX_WORD_LEN];
    logic [LEN_W-1:0] r_word_len;
    logic [LEN_W-1:0] n_word_len;
    logic             r_too_long;
    logic             n_too_long;

    logic                   accept;
    logic                   is_delim;
    logic [7:0]             lc_char;
    logic                   append;
    logic                   has_room;
    logic [LEN_W-1:0]       eff_len;
    logic                   eff_too_long;
    logic                   close_word;
    logic                   fits;
    logic [8*VOC_CHARS-1:0] eff_chars;
    t_word_class            word_class;

    // transfer and character decode
    assign o_ready  = i_q_status.can_push;
    assign accept   = i_valid && o_ready;
    assign is_delim = (i_char == CH_SPACE) || (i_char == CH_HYPHEN) ||
                      (i_char == CH_COMMA);
    assign lc_char  = (i_char >= CH_UPPER_A && i_char <= CH_UPPER_Z) ?
                      (i_char | CASE_BIT) : i_char;
    assign append   = i_present && !is_delim;
    assign has_room = r_word_len < LEN_W'(MAX_WORD_LEN);

    // word as it stands once this character is taken in
    assign eff_len      = (append && has_room) ? r_word_len + LEN_W'(1) : r_word_len;
    assign eff_too_long = r_too_long || (append && !has_room);
    assign close_word   = (i_present && is_delim) || i_last;

    always_comb begin
        for (int p = 0; p < VOC_CHARS; p++) begin
            eff_chars[p*8 +: 8] = (append && r_word_len == LEN_W'(p)) ?
                                  lc_char : r_word_chars[p];
        end
    end

    // vocabulary match
    assign fits = !eff_too_long && (eff_len <= LEN_W'(VOC_CHARS));

    always_comb begin
        if (fits) begin
            word_class = classify_word(eff_chars, eff_len[VOC_LEN_W-1:0]);
        end else begin
            word_class = '{WK_NONE, 7'd0};
        end
    end

    // token out, unknown words only travel when they end the string
    assign o_push        = accept && close_word && (i_last || word_class.kind != WK_NONE);
    assign o_token.kind  = word_class.kind;
    assign o_token.value = word_class.value;
    assign o_token.last  = i_last;

    // word length and overflow marker
    always_comb begin
        n_word_len = r_word_len;
        n_too_long = r_too_long;
        if (accept) begin
            if (close_word) begin
                n_word_len = '0;
                n_too_long = 1'b0;
            end else if (append) begin
                n_word_len = eff_len;
                n_too_long = eff_too_long;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_len <= '0;
            r_too_long <= 1'b0;
        end else begin
            r_word_len <= n_word_len;
            r_too_long <= n_too_long;
        end
    end

    // letter storage
    always_ff @(posedge i_clk) begin
        if (accept && append && has_room) begin
            r_word_chars[r_word_len[IDX_W-1:0]] <= lc_char;
        end
    end

endmodule

### src/enwp_queue.sv
// ----------------------------------------------------------------------------
// enwp_queue
// short token queue that lets front and back stall on their own
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module enwp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  enwp_pkg::t_token    i_token,
    input  logic                i_pop,
    output enwp_pkg::t_token    o_head,
    output enwp_pkg::t_q_status o_status
);
    import enwp_pkg::*;

    t_token             r_slots [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic               do_push;
    logic               do_pop;

    // status and head
    assign o_status.can_push   = r_count != Q_CNT_W'(Q_DEPTH);
    assign o_status.head_valid = r_count != '0;
    assign o_head              = r_slots[r_rd_ptr];

    assign do_push = i_push && o_status.can_push;
    assign do_pop  = i_pop && o_status.head_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_token;
        end
    end

endmodule

### src/enwp_back.sv
// ----------------------------------------------------------------------------
// enwp_back
// applies tokens to the partial sum and total, holds the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module enwp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  enwp_pkg::t_token    i_head,
    input  enwp_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [30:0]         o_value,
    output logic                o_overflowed
);
    import enwp_pkg::*;

    logic [30:0] r_partial;
    logic [30:0] n_partial;
    logic [30:0] r_total;
    logic [30:0] n_total;
    logic        r_zero_seen;
    logic        n_zero_seen;
    logic        r_ovf;
    logic        n_ovf;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [30:0] r_out_value;
    logic        r_out_ovf;

    logic [FACTOR_W-1:0] factor;
    logic [50:0]         product;
    logic [51:0]         scaled_total;
    logic [31:0]         plus_sum;
    logic [31:0]         final_sum;
    logic [30:0]         final_value;
    logic                final_ovf;

    // a closing token waits while the result register is still full
    assign o_pop = i_q_status.head_valid &&
                   (!i_head.last || !r_out_valid || i_ready);

    // one shared constant multiplier
    always_comb begin
        unique case (i_head.kind)
            WK_HUNDRED:  factor = FACTOR_HUNDRED;
            WK_THOUSAND: factor = FACTOR_THOUSAND;
            WK_MILLION:  factor = FACTOR_MILLION;
            default:     factor = '0;
        endcase
    end

    assign product      = 51'(r_partial) * 51'(factor);
    assign scaled_total = 52'(r_total) + 52'(product);
    assign plus_sum     = 32'(r_partial) + 32'(i_head.value);

    // word effect with saturation
    always_comb begin
        n_partial   = r_partial;
        n_total     = r_total;
        n_zero_seen = r_zero_seen;
        n_ovf       = r_ovf;
        if (!r_zero_seen) begin
            unique case (i_head.kind)
                WK_PLUS: begin
                    if (plus_sum > 32'(VALUE_MAX)) begin
                        n_partial = VALUE_MAX;
                        n_ovf     = 1'b1;
                    end else begin
                        n_partial = plus_sum[30:0];
                    end
                end
                WK_HUNDRED: begin
                    if (product > 51'(VALUE_MAX)) begin
                        n_partial = VALUE_MAX;
                        n_ovf     = 1'b1;
                    end else begin
                        n_partial = product[30:0];
                    end
                end
                WK_THOUSAND, WK_MILLION: begin
                    n_partial = '0;
                    if (scaled_total > 52'(VALUE_MAX)) begin
                        n_total = VALUE_MAX;
                        n_ovf   = 1'b1;
                    end else begin
                        n_total = scaled_total[30:0];
                    end
                end
                WK_ZERO: begin
                    n_zero_seen = 1'b1;
                end
                WK_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // end of string value
    assign final_sum = 32'(n_total) + 32'(n_partial);

    always_comb begin
        final_value = n_total;
        final_ovf   = n_ovf;
        if (!n_zero_seen) begin
            if (final_sum > 32'(VALUE_MAX)) begin
                final_value = VALUE_MAX;
                final_ovf   = 1'b1;
            end else begin
                final_value = final_sum[30:0];
            end
        end
    end

    // result register handshake
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (o_pop && i_head.last) begin
            n_out_valid = 1'b1;
        end
    end

    // accumulator state, cleared after each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_total     <= '0;
            r_zero_seen <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (i_head.last) begin
                    r_partial   <= '0;
                    r_total     <= '0;
                    r_zero_seen <= 1'b0;
                    r_ovf       <= 1'b0;
                end else begin
                    r_partial   <= n_partial;
                    r_total     <= n_total;
                    r_zero_seen <= n_zero_seen;
                    r_ovf       <= n_ovf;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_out_value <= final_value;
            r_out_ovf   <= final_ovf;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value      = r_out_value;
    assign o_overflowed = r_out_ovf;

endmodule

### src/enwp_checker.sv
// ----------------------------------------------------------------------------
// enwp_checker
// port level checks of the number word parser, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "english_number_words_parser_macros.svh"

module enwp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // a result waiting for transfer stays offered
    `ENWP_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

    // a stalled result keeps its value and flag
    `ENWP_ASSERT_NEXT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // input back-pressure only comes from a result that waits
    `ENWP_ASSERT_NOW(a_stall_cause, !o_s_axis_tready, o_m_axis_tvalid)

    // the padding bit above the value stays clear
    `ENWP_ASSERT_NOW(a_pad_clear, o_m_axis_tvalid, !o_m_axis_tdata[31])

endmodule

bind english_number_words_parser enwp_checker u_enwp_checker (.*);
